>>> rtl/pszn_pkg.sv
// shared constants, widths and types of the point set z-score normalizer
// no dependencies
`timescale 1ns / 1ps

package pszn_pkg;

    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 12;
    localparam int COORD_W    = 10;
    localparam int OUT_W      = 16;

    localparam int PTR_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = COORD_W + CNT_W;
    localparam int SQ_W   = 2 * COORD_W;
    localparam int QSUM_W = SQ_W + CNT_W;
    localparam int NQ_W   = QSUM_W + CNT_W;
    localparam int SS_W   = 2 * SUM_W;
    localparam int D_W    = NQ_W;
    localparam int DIFF_W = ((SS_W > NQ_W) ? SS_W : NQ_W) + 1;
    localparam int ND_W   = D_W + CNT_W;
    localparam int NV_W   = CNT_W + 1 + COORD_W;
    localparam int E_W    = ((NV_W > SUM_W) ? NV_W : SUM_W) + 1;
    localparam int MAG_W  = E_W;
    localparam int E2_W   = 2 * MAG_W;
    localparam int R0_W   = E2_W + CNT_W;
    localparam int R_W    = R0_W + 2 * FRAC_BITS;
    localparam int ROOT_W = OUT_W - 1;
    localparam int SQIN_W = 2 * ROOT_W;
    localparam int SR_W   = ROOT_W + 3;
    localparam int ITER_W = $clog2(R_W);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FEW      = 2'd1,
        ST_ZERO_DEV = 2'd2,
        ST_DROPPED  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_STORE,
        OP_DPROD,
        OP_DDIFF,
        OP_NDPROD,
        OP_READ,
        OP_ESCALE,
        OP_EDIFF,
        OP_ESQ,
        OP_RPROD,
        OP_DIV,
        OP_SQINIT,
        OP_SQRT,
        OP_RESULT,
        OP_NEXT,
        OP_CLEAR
    } dp_op_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_DPROD,
        S_DDIFF,
        S_NDPROD,
        S_READ,
        S_ESCALE,
        S_EDIFF,
        S_ESQ,
        S_RPROD,
        S_DIV,
        S_SQINIT,
        S_SQRT,
        S_RESULT,
        S_EMIT
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   axis;
    } dp_cmd_t;

    typedef struct packed {
        logic rd_last;
    } dp_stat_t;

endpackage

>>> rtl/pszn_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pszn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pszn_dp.sv
// datapath: point store, running sums, deviation terms, shared divider and root unit
// depends on pszn_pkg and pszn_ram
`timescale 1ns / 1ps

module pszn_dp
    import pszn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    output dp_stat_t                  stat,
    output logic signed [OUT_W-1:0]   norm_x,
    output logic signed [OUT_W-1:0]   norm_y,
    output logic [1:0]                status,
    output logic                      last
);

    // set state
    logic [CNT_W-1:0]        point_count_reg;
    logic                    overflow_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg;
    logic [QSUM_W-1:0]       qx_reg, qy_reg;
    logic [PTR_W-1:0]        rd_idx_reg;

    // per set terms
    logic [NQ_W-1:0] nqx_reg, nqy_reg;
    logic [SS_W-1:0] ssx_reg, ssy_reg;
    logic [D_W-1:0]  dx_reg, dy_reg;
    logic [ND_W-1:0] ndx_reg, ndy_reg;
    logic            zx_reg, zy_reg;
    status_t         status_reg;

    // per point terms
    logic signed [NV_W-1:0] nvx_reg, nvy_reg;
    logic [MAG_W-1:0]       exm_reg, eym_reg;
    logic                   exn_reg, eyn_reg;
    logic [E2_W-1:0]        e2_reg;
    logic [R_W-1:0]         q_reg;
    logic [ND_W-1:0]        rem_reg;
    logic [SR_W-1:0]        sr_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic                   sat_reg;
    logic signed [OUT_W-1:0] out_x_reg, out_y_reg;

    logic                      can_store;
    logic                      ram_we;
    logic [2*COORD_W-1:0]      ram_rdata;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic signed [SQ_W-1:0]    sq_x, sq_y;
    logic signed [SS_W-1:0]    ssx_w, ssy_w;
    logic [NQ_W-1:0]           nqx_w, nqy_w;
    logic [DIFF_W-1:0]         dx_diff, dy_diff;
    logic [ND_W-1:0]           ndx_w, ndy_w;
    logic signed [NV_W-1:0]    nvx_w, nvy_w;
    logic signed [E_W-1:0]     ex_w, ey_w;
    logic [MAG_W-1:0]          cur_mag;
    logic [E2_W-1:0]           e2_w;
    logic [CNT_W-1:0]          nm1;
    logic [R0_W-1:0]           r0_w;
    logic [ND_W-1:0]           div_d;
    logic [ND_W:0]             div_sh;
    logic                      div_ge;
    logic [SR_W-1:0]           sr_sh, sr_trial;
    logic                      sr_ge;
    logic                      cur_neg, cur_zero;
    logic signed [OUT_W-1:0]   result_w;
    logic                      few;

    assign can_store = point_count_reg < CNT_W'(MAX_POINTS);
    assign ram_we    = (cmd.op == OP_STORE) && can_store;

    pszn_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (point_count_reg[PTR_W-1:0]),
        .wdata ({point_y, point_x}),
        .re    (cmd.op == OP_READ),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[COORD_W-1:0];
    assign rd_y = ram_rdata[2*COORD_W-1:COORD_W];

    assign sq_x = point_x * point_x;
    assign sq_y = point_y * point_y;

    assign nqx_w = point_count_reg * qx_reg;
    assign nqy_w = point_count_reg * qy_reg;
    assign ssx_w = sx_reg * sx_reg;
    assign ssy_w = sy_reg * sy_reg;

    assign dx_diff = DIFF_W'(nqx_reg) - DIFF_W'(ssx_reg);
    assign dy_diff = DIFF_W'(nqy_reg) - DIFF_W'(ssy_reg);

    assign ndx_w = dx_reg * point_count_reg;
    assign ndy_w = dy_reg * point_count_reg;

    assign nvx_w = $signed({1'b0, point_count_reg}) * rd_x;
    assign nvy_w = $signed({1'b0, point_count_reg}) * rd_y;

    assign ex_w = E_W'(nvx_reg) - E_W'(sx_reg);
    assign ey_w = E_W'(nvy_reg) - E_W'(sy_reg);

    assign cur_mag = cmd.axis ? eym_reg : exm_reg;
    assign e2_w    = cur_mag * cur_mag;
    assign nm1     = point_count_reg - CNT_W'(1);
    assign r0_w    = e2_reg * nm1;

    // restoring divide, one quotient bit per step, quotient shifts into q_reg
    assign div_d  = cmd.axis ? ndy_reg : ndx_reg;
    assign div_sh = {rem_reg, q_reg[R_W-1]};
    assign div_ge = div_sh >= {1'b0, div_d};

    // bit-serial square root over the low bits of the quotient
    assign sr_sh    = {sr_reg[SR_W-3:0], q_reg[SQIN_W-1:SQIN_W-2]};
    assign sr_trial = SR_W'({root_reg, 2'b01});
    assign sr_ge    = sr_sh >= sr_trial;

    assign cur_neg  = cmd.axis ? eyn_reg : exn_reg;
    assign cur_zero = cmd.axis ? zy_reg : zx_reg;

    always_comb
    begin
        if (cur_zero)
        begin
            result_w = '0;
        end
        else if (sat_reg)
        begin
            result_w = cur_neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        else if (cur_neg)
        begin
            result_w = -$signed({1'b0, root_reg});
        end
        else
        begin
            result_w = $signed({1'b0, root_reg});
        end
    end

    assign few = point_count_reg < CNT_W'(2);

    // control state of the set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            overflow_reg    <= 1'b0;
            sx_reg          <= '0;
            sy_reg          <= '0;
            qx_reg          <= '0;
            qy_reg          <= '0;
            rd_idx_reg      <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_STORE:
                begin
                    if (can_store)
                    begin
                        point_count_reg <= point_count_reg + CNT_W'(1);
                        sx_reg <= sx_reg + SUM_W'(point_x);
                        sy_reg <= sy_reg + SUM_W'(point_y);
                        qx_reg <= qx_reg + QSUM_W'(unsigned'(sq_x));
                        qy_reg <= qy_reg + QSUM_W'(unsigned'(sq_y));
                    end
                    else
                    begin
                        overflow_reg <= 1'b1;
                    end
                end
                OP_NEXT:
                begin
                    rd_idx_reg <= rd_idx_reg + PTR_W'(1);
                end
                OP_CLEAR:
                begin
                    point_count_reg <= '0;
                    overflow_reg    <= 1'b0;
                    sx_reg          <= '0;
                    sy_reg          <= '0;
                    qx_reg          <= '0;
                    qy_reg          <= '0;
                    rd_idx_reg      <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_DPROD:
            begin
                nqx_reg <= nqx_w;
                nqy_reg <= nqy_w;
                ssx_reg <= unsigned'(ssx_w);
                ssy_reg <= unsigned'(ssy_w);
            end
            OP_DDIFF:
            begin
                dx_reg <= dx_diff[D_W-1:0];
                dy_reg <= dy_diff[D_W-1:0];
            end
            OP_NDPROD:
            begin
                ndx_reg <= ndx_w;
                ndy_reg <= ndy_w;
                zx_reg  <= few || (dx_reg == '0);
                zy_reg  <= few || (dy_reg == '0);
                if (few)
                begin
                    status_reg <= ST_FEW;
                end
                else if (overflow_reg)
                begin
                    status_reg <= ST_DROPPED;
                end
                else if ((dx_reg == '0) || (dy_reg == '0))
                begin
                    status_reg <= ST_ZERO_DEV;
                end
                else
                begin
                    status_reg <= ST_OK;
                end
            end
            OP_ESCALE:
            begin
                nvx_reg <= nvx_w;
                nvy_reg <= nvy_w;
            end
            OP_EDIFF:
            begin
                exn_reg <= ex_w[E_W-1];
                eyn_reg <= ey_w[E_W-1];
                exm_reg <= ex_w[E_W-1] ? MAG_W'(unsigned'(-ex_w)) : MAG_W'(unsigned'(ex_w));
                eym_reg <= ey_w[E_W-1] ? MAG_W'(unsigned'(-ey_w)) : MAG_W'(unsigned'(ey_w));
            end
            OP_ESQ:
            begin
                e2_reg <= e2_w;
            end
            OP_RPROD:
            begin
                q_reg   <= {r0_w, {(2*FRAC_BITS){1'b0}}};
                rem_reg <= '0;
            end
            OP_DIV:
            begin
                q_reg   <= {q_reg[R_W-2:0], div_ge};
                rem_reg <= div_ge ? ND_W'(div_sh - {1'b0, div_d}) : div_sh[ND_W-1:0];
            end
            OP_SQINIT:
            begin
                // a root of 2^(OUT_W-1) or more saturates
                sat_reg  <= |q_reg[R_W-1:SQIN_W];
                sr_reg   <= '0;
                root_reg <= '0;
            end
            OP_SQRT:
            begin
                q_reg    <= {q_reg[R_W-3:0], 2'b00};
                sr_reg   <= sr_ge ? SR_W'(sr_sh - sr_trial) : sr_sh;
                root_reg <= {root_reg[ROOT_W-2:0], sr_ge};
            end
            OP_RESULT:
            begin
                if (cmd.axis)
                begin
                    out_y_reg <= result_w;
                end
                else
                begin
                    out_x_reg <= result_w;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.rd_last = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == point_count_reg;

    assign norm_x = out_x_reg;
    assign norm_y = out_y_reg;
    assign status = status_reg;
    assign last   = stat.rd_last;

endmodule

>>> rtl/pszn_ctrl.sv
// controller: sequences loading, per set terms, per point divide and root, and output
// depends on pszn_pkg
`timescale 1ns / 1ps

module pszn_ctrl
    import pszn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     end_of_set,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output logic     in_stall,
    output logic     out_valid,
    output dp_cmd_t  cmd
);

    state_t            state_reg, state_next;
    logic              axis_reg, axis_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            axis_reg  <= 1'b0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        iter_next  = iter_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        cmd.op     = OP_IDLE;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = OP_STORE;
                    if (end_of_set)
                    begin
                        state_next = S_DPROD;
                    end
                end
            end
            S_DPROD:
            begin
                cmd.op     = OP_DPROD;
                state_next = S_DDIFF;
            end
            S_DDIFF:
            begin
                cmd.op     = OP_DDIFF;
                state_next = S_NDPROD;
            end
            S_NDPROD:
            begin
                cmd.op     = OP_NDPROD;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.op     = OP_READ;
                state_next = S_ESCALE;
            end
            S_ESCALE:
            begin
                cmd.op     = OP_ESCALE;
                state_next = S_EDIFF;
            end
            S_EDIFF:
            begin
                cmd.op     = OP_EDIFF;
                axis_next  = 1'b0;
                state_next = S_ESQ;
            end
            S_ESQ:
            begin
                cmd.op     = OP_ESQ;
                state_next = S_RPROD;
            end
            S_RPROD:
            begin
                cmd.op     = OP_RPROD;
                iter_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op    = OP_DIV;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(R_W - 1))
                begin
                    state_next = S_SQINIT;
                end
            end
            S_SQINIT:
            begin
                cmd.op     = OP_SQINIT;
                iter_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op    = OP_SQRT;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(ROOT_W - 1))
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                cmd.op = OP_RESULT;
                if (axis_reg)
                begin
                    axis_next  = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    axis_next  = 1'b1;
                    state_next = S_ESQ;
                end
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (stat.rd_last)
                    begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.op     = OP_NEXT;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("item accepted while a result is pending");

    a_end_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && in_valid && end_of_set) |=> (state_reg == S_DPROD))
        else $error("final item did not start computation");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && iter_reg == ITER_W'(R_W - 1)) |=> (state_reg == S_SQINIT))
        else $error("divide did not end after its last step");

    a_emit_after_both_axes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (axis_reg == 1'b0 && $past(state_reg) != S_DIV))
        else $error("result shown before both axes finished");

endmodule

>>> rtl/point_set_zscore_normalizer_core.sv
// top level of the point set z-score normalizer
// depends on pszn_pkg, pszn_ctrl and pszn_dp
`timescale 1ns / 1ps

// Points of a set are taken one per cycle and kept in a 64-entry point store while the
// axis sums and sums of squares build up. The item marked end_of_set closes the set: the
// block then stalls its input and forms n*Q - S*S per axis, scaled by n. For each stored
// point in load order it reads the point, scales it by n and subtracts the axis sum; then
// per axis it squares that, scales it by n-1, divides in the shared restoring divider to
// a 69-bit quotient, takes the bit-serial square root and forms the final value before
// the result is offered. Each result waits in the output registers until taken; the next
// point starts once it is. After the result marked last is taken the block accepts the
// next set. Points past the store's capacity are dropped and reported in status.

module point_set_zscore_normalizer_core
    import pszn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic                      end_of_set,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [OUT_W-1:0]   norm_x,
    output logic signed [OUT_W-1:0]   norm_y,
    output logic [1:0]                status,
    output logic                      last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pszn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .end_of_set (end_of_set),
        .out_stall  (out_stall),
        .stat       (stat),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .cmd        (cmd)
    );

    pszn_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .point_x (point_x),
        .point_y (point_y),
        .stat    (stat),
        .norm_x  (norm_x),
        .norm_y  (norm_y),
        .status  (status),
        .last    (last)
    );

endmodule

>>> verif/point_set_zscore_normalizer_core_test.sv
// testbench for point_set_zscore_normalizer_core: loads point sets, predicts the z-scores
// in exact integer arithmetic and checks every result item; depends on pszn_pkg and the RTL
`timescale 1ns / 1ps

module point_set_zscore_normalizer_core_test;
    import pszn_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      eos;
        logic                      typed;
        logic signed [OUT_W-1:0]   ex;
        logic signed [OUT_W-1:0]   ey;
        status_t                   st;
        logic                      lst;
    } point_item_t;

    typedef struct {
        logic signed [OUT_W-1:0] zx;
        logic signed [OUT_W-1:0] zy;
        status_t                 st;
        logic                    lst;
    } zscore_t;

    localparam int CYCLE_LIMIT = 2000000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      end_of_set;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [OUT_W-1:0]   norm_x;
    logic signed [OUT_W-1:0]   norm_y;
    logic [1:0]                status;
    logic                      last;

    point_item_t in_flight[$];
    point_item_t set_points[$];
    zscore_t     expected_z[$];
    logic        dropped_seen;
    int          fail_count;
    int          result_count;
    int          item_count;
    int          set_count;
    int          big_sets;
    int          cycle_count;
    int          phase;

    point_set_zscore_normalizer_core DUT (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", result_count, what);
        fail_count++;
    endtask

    // largest m with m*m*n*d <= e*e*(n-1)*4^FRAC_BITS, signed and saturated
    function automatic logic signed [OUT_W-1:0] zscore_of(input longint e, input longint n,
                                                          input longint d);
        logic [127:0] mag;
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        if (d == 0 || n < 2)
            return '0;
        mag = 128'((e < 0) ? -e : e);
        rhs = (mag * mag * 128'(n) - mag * mag) << (2 * FRAC_BITS);
        lo = '0;
        hi = 128'(32768);
        while (lo < hi)
        begin
            mid = (lo + hi + 128'(1)) / 128'(2);
            lhs = mid * mid * 128'(n) * 128'(d);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 128'(1);
        end
        if (e < 0)
            return -lo[OUT_W-1:0];
        return (lo > 128'(32767)) ? 16'sd32767 : lo[OUT_W-1:0];
    endfunction

    task automatic predict_item(input point_item_t it);
        longint  n;
        longint  sx;
        longint  sy;
        longint  qx;
        longint  qy;
        longint  dx;
        longint  dy;
        status_t st;
        zscore_t z;
        sx = 0;
        sy = 0;
        qx = 0;
        qy = 0;
        if (set_points.size() < MAX_POINTS)
            set_points.insert(set_points.size(), it);
        else
            dropped_seen = 1'b1;
        if (!it.eos)
            return;
        n = set_points.size();
        foreach (set_points[i])
        begin
            sx += set_points[i].px;
            sy += set_points[i].py;
            qx += set_points[i].px * set_points[i].px;
            qy += set_points[i].py * set_points[i].py;
        end
        dx = n * qx - sx * sx;
        dy = n * qy - sy * sy;
        if (n < 2)
            st = ST_FEW;
        else if (dropped_seen)
            st = ST_DROPPED;
        else if (dx == 0 || dy == 0)
            st = ST_ZERO_DEV;
        else
            st = ST_OK;
        foreach (set_points[i])
        begin
            if (set_points[i].typed)
            begin
                z.zx = set_points[i].ex;
                z.zy = set_points[i].ey;
                z.st = set_points[i].st;
                z.lst = set_points[i].lst;
            end
            else
            begin
                z.zx = zscore_of(n * set_points[i].px - sx, n, dx);
                z.zy = zscore_of(n * set_points[i].py - sy, n, dy);
                z.st = st;
                z.lst = (i == set_points.size() - 1);
            end
            expected_z.insert(expected_z.size(), z);
        end
        set_points.delete();
        dropped_seen = 1'b0;
        set_count++;
    endtask

    // input side: predict on every accepted item
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_item(in_flight.pop_front());
            item_count++;
        end
    end

    // output side: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        zscore_t z;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_z.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                z = expected_z.pop_front();
                if (norm_x !== z.zx)
                    report_mismatch($sformatf("norm_x %0d, want %0d", norm_x, z.zx));
                if (norm_y !== z.zy)
                    report_mismatch($sformatf("norm_y %0d, want %0d", norm_y, z.zy));
                if (status !== z.st)
                    report_mismatch($sformatf("status %0d, want %0d", status, z.st));
                if (last !== z.lst)
                    report_mismatch($sformatf("last %0b, want %0b", last, z.lst));
            end
            result_count++;
        end
    end

    always @(posedge clk)
    begin
        if (phase == 2)
            out_stall <= ($urandom_range(0, 99) < 85);
        else if (phase == 3)
            out_stall <= ($urandom_range(0, 99) < 35);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_point(input point_item_t it);
        int idle_pct;
        idle_pct = (phase == 1) ? 85 : (phase == 3) ? 35 : 0;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge clk);
        end
        in_flight.insert(in_flight.size(), it);
        in_valid   <= 1'b1;
        point_x    <= it.px;
        point_y    <= it.py;
        end_of_set <= it.eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic point_item_t plain_point(input int x, input int y, input logic eos);
        point_item_t it;
        it.px = COORD_W'(x);
        it.py = COORD_W'(y);
        it.eos = eos;
        it.typed = 1'b0;
        it.ex = '0;
        it.ey = '0;
        it.st = ST_OK;
        it.lst = 1'b0;
        return it;
    endfunction

    function automatic point_item_t known_point(input int x, input int y, input logic eos,
                                                input int ex, input int ey,
                                                input status_t st, input logic lst);
        point_item_t it;
        it = plain_point(x, y, eos);
        it.typed = 1'b1;
        it.ex = OUT_W'(ex);
        it.ey = OUT_W'(ey);
        it.st = st;
        it.lst = lst;
        return it;
    endfunction

    task automatic drain_set_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_z.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic send_random_set();
        int          r;
        int          size;
        int          cx;
        logic        flat_x;
        logic        flat_y;
        point_item_t it;
        r = $urandom_range(0, 19);
        // a full store and two overfull ones are always reached
        if (big_sets < 3 && (r == 0 || set_count >= 6 * (big_sets + 1)))
        begin
            size = MAX_POINTS + ((big_sets == 0) ? 0 : $urandom_range(1, 4));
            big_sets++;
        end
        else if (r < 3)
            size = 1;
        else
            size = $urandom_range(2, 8);
        flat_x = ($urandom_range(0, 9) == 0);
        flat_y = ($urandom_range(0, 9) == 0);
        cx = $urandom_range(0, 1023);
        for (int i = 0; i < size; i++)
        begin
            if ($urandom_range(0, 1))
                it = plain_point($urandom_range(0, 1023), $urandom_range(0, 1023), 1'b0);
            else
                it = plain_point($signed($urandom_range(0, 800)) - 400,
                                 $signed($urandom_range(0, 600)) - 300, 1'b0);
            if (flat_x)
                it.px = COORD_W'(cx);
            if (flat_y)
                it.py = COORD_W'(cx + 3);
            it.eos = (i == size - 1);
            send_point(it);
        end
    endtask

    initial
    begin
        point_item_t directed[$];
        int          target;
        fail_count = 0;
        result_count = 0;
        item_count = 0;
        set_count = 0;
        big_sets = 0;
        cycle_count = 0;
        phase = 0;
        dropped_seen = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        point_x    <= '0;
        point_y    <= '0;
        end_of_set <= 1'b0;
        out_stall  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single point, two extreme points, one flat axis, both axes flat, then two mixed sets
        directed.insert(directed.size(), known_point(100, -50, 1, 0, 0, ST_FEW, 1));
        directed.insert(directed.size(),
                        known_point(-512, -300, 0, -2896, -2896, ST_OK, 0));
        directed.insert(directed.size(), known_point(511, 300, 1, 2896, 2896, ST_OK, 1));
        directed.insert(directed.size(), known_point(5, 7, 0, 0, 2896, ST_ZERO_DEV, 0));
        directed.insert(directed.size(), known_point(5, -3, 1, 0, -2896, ST_ZERO_DEV, 1));
        directed.insert(directed.size(), known_point(-512, -512, 0, 0, 0, ST_ZERO_DEV, 0));
        directed.insert(directed.size(), known_point(-512, -512, 1, 0, 0, ST_ZERO_DEV, 1));
        directed.insert(directed.size(), plain_point(-400, 511, 0));
        directed.insert(directed.size(), plain_point(400, -512, 0));
        directed.insert(directed.size(), plain_point(0, 0, 0));
        directed.insert(directed.size(), plain_point(-1, 1, 0));
        directed.insert(directed.size(), plain_point(511, -300, 1));
        directed.insert(directed.size(), plain_point(1, 1, 0));
        directed.insert(directed.size(), plain_point(1, 2, 0));
        directed.insert(directed.size(), plain_point(1, 3, 0));
        directed.insert(directed.size(), plain_point(500, 3, 1));
        foreach (directed[i])
            send_point(directed[i]);
        drain_set_outputs();

        for (int p = 0; p < 4; p++)
        begin
            phase = p;
            target = item_count + 56;
            while (item_count < target)
                send_random_set();
            drain_set_outputs();
        end

        phase = 0;
        $display("%0d points in %0d sets loaded, %0d normalized results checked",
                 item_count, set_count, result_count);
        $display("sets covered single points, flat axes, a full store and dropped points");
        if (fail_count == 0 && expected_z.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> point_set_zscore_normalizer_core.f
rtl/pszn_pkg.sv
rtl/pszn_ram.sv
rtl/pszn_dp.sv
rtl/pszn_ctrl.sv
rtl/point_set_zscore_normalizer_core.sv
verif/point_set_zscore_normalizer_core_test.sv
